FILE: sv/xefs_pkg.sv
// shared types and constants for the x86 enter frame sequencer
// used by x86_enter_frame_sequencer; no other dependencies
package xefs_pkg;

  localparam int ADDR_WIDTH  = 64;
  localparam int MAX_NESTING = 32;
  localparam int NEST_W      = $clog2(MAX_NESTING + 1);

  localparam logic [63:0] ADDR_MASK  = {64{1'b1}} >> (64 - ADDR_WIDTH);
  localparam logic [63:0] SEG_MASK   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [3:0]  ADDR_BYTES = 4'((ADDR_WIDTH + 7) / 8);
  localparam logic [3:0]  SEG_BYTES  = 4'd4;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 264;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_BASE     = 8'd1;

  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_STORE = 2'd1,
    KIND_COPY  = 2'd2,
    KIND_FINAL = 2'd3
  } op_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_BOTTOM,
    ST_PROBE,
    ST_PUSH_FP,
    ST_SRC_INIT,
    ST_SRC_DEC,
    ST_COPY,
    ST_PUSH_FRAME,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [63:0] new_stack_pointer;
    logic [3:0]  width_bytes;
    logic [63:0] data;
    logic [63:0] source_address;
    logic [63:0] dest_address;
    op_kind_t    op_kind;
  } out_item_t;

endpackage

FILE: sv/x86_enter_frame_sequencer.sv
// x86 enter frame sequencer: expands one enter instruction into its memory items
// depends on xefs_pkg; single module, one shared 64-bit add/subtract unit
//
// usage
//   s_* channel takes one instruction item; m_* channel gives its result items in
//   order: probe, store of the old frame pointer, nesting-1 display copies, store
//   of the new frame pointer when nesting is nonzero, then a final item with tlast
//   carrying the new frame and stack pointers
//   cfg_* channel writes address_mode (index 0) and stack_segment_base (index 1);
//   cfg_ready is always high, other indexes are ignored
//   the first result, the probe, is registered after the ST_FRAME and ST_BOTTOM
//   setup steps; each instruction runs accept, ST_FRAME, ST_BOTTOM, a step per
//   probe, store and final item, ST_SRC_DEC then ST_COPY per display copy after an
//   ST_SRC_INIT step, and no new instruction is taken until it ends; all address
//   math goes through the one shared adder
//   s_tready is high only between instructions
//   m_* has an output register; while the receiver stalls the sequencer holds in
//   any step that gives an item and resumes when the slot frees
//   reset (rst, synchronous) returns to idle, drops any pending result, and sets
//   address_mode to 64-bit and the segment base to zero
module x86_enter_frame_sequencer
  import xefs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // mode[1:0], stack_pointer[65:2], frame_pointer[129:66], local_bytes[145:130],
  // nesting_raw[153:146], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // op_kind[1:0], dest_address[65:2], source_address[129:66], data[193:130],
  // width_bytes[197:194], new_stack_pointer[261:198], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        address_mode;
  logic [31:0] stack_segment_base;

  state_t      state;
  state_t      state_next;

  logic [1:0]        mode;
  logic [3:0]        op;
  logic [63:0]       am;
  logic [63:0]       base;
  logic              seg;
  logic [63:0]       sp;
  logic [63:0]       fp;
  logic [15:0]       alloc;
  logic [NEST_W-1:0] nest;
  logic [NEST_W-1:0] cnt;
  logic [63:0]       frame;
  logic [63:0]       bottom;
  logic [63:0]       ecur;
  logic [63:0]       esrc;

  logic        out_valid;
  out_item_t   out_item;
  logic        out_last;

  logic        in_fire;
  logic        slot_free;
  logic        emit;
  logic [63:0] unit_a;
  logic [63:0] unit_b;
  logic        unit_sub;
  logic [63:0] unit_y;
  logic [63:0] om;
  logic [9:0]  op_nest;
  out_item_t   item_next;
  logic        last_next;

  logic [1:0]  in_mode;
  logic [7:0]  in_nest;

  assign in_mode   = s_tdata[1:0];
  assign in_nest   = s_tdata[153:146];
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;
  assign cfg_ready = 1'b1;

  assign unit_y = (unit_a + (unit_sub ? ~unit_b : unit_b) + {63'b0, unit_sub}) & am;

  // display area size: operand size times nesting
  assign op_nest = op * nest;

  always_comb begin
    case (mode)
      MODE_16: om = 64'h0000_0000_0000_FFFF;
      MODE_32: om = 64'h0000_0000_FFFF_FFFF;
      default: om = {64{1'b1}};
    endcase
  end

  // unit operands and result item per step
  always_comb begin
    unit_a    = 64'b0;
    unit_b    = 64'b0;
    unit_sub  = 1'b0;
    item_next = '0;
    last_next = 1'b0;
    emit      = 1'b0;
    item_next.width_bytes = op;
    case (state)
      ST_FRAME: begin
        unit_a   = sp;
        unit_b   = {60'b0, op};
        unit_sub = 1'b1;
      end
      ST_BOTTOM: begin
        unit_a   = frame;
        unit_b   = {54'b0, op_nest} + {48'b0, alloc};
        unit_sub = 1'b1;
      end
      ST_PROBE: begin
        unit_a = bottom;
        unit_b = base;
        item_next.op_kind      = KIND_PROBE;
        item_next.dest_address = unit_y;
        emit = slot_free;
      end
      ST_PUSH_FP: begin
        unit_a = frame;
        unit_b = base;
        item_next.op_kind      = KIND_STORE;
        item_next.dest_address = unit_y;
        item_next.data         = fp & om;
        emit = slot_free;
      end
      ST_SRC_INIT: begin
        unit_a = fp;
        unit_b = base;
      end
      ST_SRC_DEC: begin
        unit_a   = esrc;
        unit_b   = {60'b0, op};
        unit_sub = 1'b1;
      end
      ST_COPY: begin
        unit_a   = ecur;
        unit_b   = {60'b0, op};
        unit_sub = 1'b1;
        item_next.op_kind        = KIND_COPY;
        item_next.dest_address   = unit_y;
        item_next.source_address = esrc;
        emit = slot_free;
      end
      ST_PUSH_FRAME: begin
        unit_a   = ecur;
        unit_b   = {60'b0, op};
        unit_sub = 1'b1;
        item_next.op_kind      = KIND_STORE;
        item_next.dest_address = unit_y;
        item_next.data         = frame;
        item_next.width_bytes  = seg ? SEG_BYTES : ADDR_BYTES;
        emit = slot_free;
      end
      ST_FINAL: begin
        item_next.op_kind           = KIND_FINAL;
        item_next.data              = frame;
        item_next.new_stack_pointer = bottom;
        last_next = 1'b1;
        emit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_fire) state_next = ST_FRAME;
      ST_FRAME:    state_next = ST_BOTTOM;
      ST_BOTTOM:   state_next = ST_PROBE;
      ST_PROBE:    if (slot_free) state_next = ST_PUSH_FP;
      ST_PUSH_FP: begin
        if (slot_free) begin
          if (nest == '0) state_next = ST_FINAL;
          else if (nest == NEST_W'(1)) state_next = ST_PUSH_FRAME;
          else state_next = ST_SRC_INIT;
        end
      end
      ST_SRC_INIT: state_next = ST_SRC_DEC;
      ST_SRC_DEC:  state_next = ST_COPY;
      ST_COPY: begin
        if (slot_free) state_next = (cnt == NEST_W'(1)) ? ST_PUSH_FRAME : ST_SRC_DEC;
      end
      ST_PUSH_FRAME: if (slot_free) state_next = ST_FINAL;
      ST_FINAL:      if (slot_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      address_mode       <= 1'b1;
      stack_segment_base <= 32'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ADDRESS_MODE) begin
          address_mode <= cfg_data[0];
        end else if (cfg_index == REG_SEG_BASE) begin
          stack_segment_base <= cfg_data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seg   <= !address_mode;
      am    <= address_mode ? ADDR_MASK : SEG_MASK;
      base  <= address_mode ? 64'b0 : {32'b0, stack_segment_base};
      mode  <= in_mode;
      case (in_mode)
        MODE_16: op <= 4'd2;
        MODE_32: op <= 4'd4;
        default: op <= 4'd8;
      endcase
      sp    <= s_tdata[65:2] & (address_mode ? ADDR_MASK : SEG_MASK);
      fp    <= s_tdata[129:66] & (address_mode ? ADDR_MASK : SEG_MASK);
      alloc <= s_tdata[145:130];
      nest  <= NEST_W'(in_nest % MAX_NESTING);
    end
    case (state)
      ST_FRAME:    frame  <= unit_y;
      ST_BOTTOM:   bottom <= unit_y;
      ST_PUSH_FP: begin
        ecur <= unit_y;
        cnt  <= nest - NEST_W'(1);
      end
      ST_SRC_INIT: esrc <= unit_y;
      ST_SRC_DEC:  esrc <= unit_y;
      ST_COPY: begin
        if (slot_free) begin
          ecur <= unit_y;
          cnt  <= cnt - NEST_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_item <= item_next;
      out_last <= last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b0, out_item};
  assign m_tlast  = out_last;

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (out_item.op_kind == KIND_FINAL)))
    else $error("tlast does not match final item");

  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_FRAME))
    else $error("sequencer did not start after input accept");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (cnt != '0))
    else $error("display copy with zero count");

endmodule
